// File: hdl/sct_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_pkg
// Shared types and constants for the SI section completeness tracker.
// ----------------------------------------------------------------------------
package sct_pkg;

   localparam int WORD_W     = 64;
   localparam int LEN_W      = 9;
   localparam int IDX_MAX_W  = 8;
   localparam int WIDX_MAX_W = 2;

   localparam logic [4:0] WRAP_NEW_BELOW = 5'd12;
   localparam logic [4:0] WRAP_OLD_FROM  = 5'd24;

   localparam logic [2:0] STAT_NEXT            = 3'd0;
   localparam logic [2:0] STAT_OLD_VERSION     = 3'd1;
   localparam logic [2:0] STAT_REPEAT          = 3'd2;
   localparam logic [2:0] STAT_OK              = 3'd3;
   localparam logic [2:0] STAT_COMPLETE        = 3'd4;
   localparam logic [2:0] STAT_REPEAT_COMPLETE = 3'd5;
   localparam logic [2:0] STAT_TABLE_FULL      = 3'd6;
   localparam logic [2:0] STAT_BAD_SECTION     = 3'd7;

   localparam logic OP_TRACK = 1'b0;
   localparam logic OP_CLEAR = 1'b1;

   typedef struct packed {
      logic                 hit;
      logic [IDX_MAX_W-1:0] hit_idx;
      logic                 free;
      logic [IDX_MAX_W-1:0] free_idx;
   } sct_match_type;

   typedef struct packed {
      logic all_set;
      logic old_bit;
   } sct_word_type;

   function automatic logic newer_version(input logic [4:0] vn, input logic [4:0] old);
      return (vn > old) || ((vn < WRAP_NEW_BELOW) && (old >= WRAP_OLD_FROM));
   endfunction

endpackage
`default_nettype wire

// File: hdl/si_section_completeness_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// si_section_completeness_tracker
// Tracks version, length and received sections of DVB SI tables per key.
// ----------------------------------------------------------------------------
//   channel   ports                          handshake
//   request   req_operation .. req_last_index  start & !busy
//   response  rsp_status                     rsp_strobe, one cycle
//
// Clear, next-table and bad-section items: strobe in the cycle after accept.
// Old-version and table-full items: busy for the lookup state only.
// Other tracked sections: busy through the lookup, a sweep over each
// 64-bit bitmap word through the shared word unit and the final status, strobe right after.
// Reset empties every entry directly; no clearing pass.
// The receiver cannot stall; a new item may be accepted during the strobe.
// ----------------------------------------------------------------------------
module si_section_completeness_tracker #(
   parameter int MAX_TABLES   = 16,
   parameter int MAX_SECTIONS = 256
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       start,
   output logic            busy,
   input  wire logic       req_operation,
   input  wire logic       req_current_flag,
   input  wire logic [4:0] req_version,
   input  wire logic [15:0] req_table_key,
   input  wire logic [7:0] req_section_index,
   input  wire logic [7:0] req_last_index,
   output logic            rsp_strobe,
   output logic [2:0]      rsp_status
);
   import sct_pkg::*;

   localparam int WORDS  = (MAX_SECTIONS + WORD_W - 1) / WORD_W;
   localparam int TIDX_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
   localparam int WIDX_W = (WORDS > 1) ? $clog2(WORDS) : 1;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_LOOK  = 2'd1;
   localparam logic [1:0] S_SWEEP = 2'd2;
   localparam logic [1:0] S_DONE  = 2'd3;

   logic [1:0] state_ff, state_in;
   logic       strobe_ff, strobe_in;
   logic [2:0] status_ff, status_in;

   logic [MAX_TABLES-1:0]                         valid_ff, valid_in;
   logic [MAX_TABLES-1:0]                         cpl_ff, cpl_in;
   logic [MAX_TABLES-1:0][LEN_W-1:0]              len_ff, len_in;
   logic [MAX_TABLES-1:0][15:0]                   key_ff, key_in;
   logic [MAX_TABLES-1:0][4:0]                    ver_ff, ver_in;
   logic [MAX_TABLES-1:0][WORDS-1:0][WORD_W-1:0]  bitmap_ff, bitmap_in;

   logic [4:0]       rver_ff, rver_in;
   logic [15:0]      rkey_ff, rkey_in;
   logic [7:0]       rsec_ff, rsec_in;
   logic [LEN_W-1:0] rlen_ff, rlen_in;
   logic [TIDX_W-1:0] slot_ff, slot_in;
   logic [WIDX_W-1:0] word_ff, word_in;
   logic             all_ff, all_in;
   logic             old_ff, old_in;

   sct_match_type     match;
   sct_word_type      wflags;
   logic [WORD_W-1:0] word_new;
   logic [TIDX_W-1:0] hit_slot;
   logic [TIDX_W-1:0] look_slot;
   logic [LEN_W-1:0]  look_len;
   logic              look_cpl;
   logic              go;
   logic              fresh;
   logic              bad_sec;
   logic              any_open;

   assign busy       = (state_ff != S_IDLE);
   assign rsp_strobe = strobe_ff;
   assign rsp_status = status_ff;
   assign hit_slot   = match.hit_idx[TIDX_W-1:0];
   assign bad_sec    = (req_section_index > req_last_index) ||
                       ({1'b0, req_last_index} >= LEN_W'(MAX_SECTIONS));
   assign any_open   = |(valid_ff & ~cpl_ff);

   sct_lookup #(
      .MAX_TABLES(MAX_TABLES)
   ) u_lookup (
      .valid (valid_ff),
      .keys  (key_ff),
      .key   (rkey_ff),
      .match (match)
   );

   sct_word_unit u_word (
      .word_cur (bitmap_ff[slot_ff][word_ff]),
      .word_idx (WIDX_MAX_W'(word_ff)),
      .len      (rlen_ff),
      .sec      (rsec_ff),
      .set_en   (!cpl_ff[slot_ff]),
      .word_new (word_new),
      .flags    (wflags)
   );

   always_comb begin
      state_in  = state_ff;
      strobe_in = 1'b0;
      status_in = status_ff;
      valid_in  = valid_ff;
      cpl_in    = cpl_ff;
      len_in    = len_ff;
      key_in    = key_ff;
      ver_in    = ver_ff;
      bitmap_in = bitmap_ff;
      rver_in   = rver_ff;
      rkey_in   = rkey_ff;
      rsec_in   = rsec_ff;
      rlen_in   = rlen_ff;
      slot_in   = slot_ff;
      word_in   = word_ff;
      all_in    = all_ff;
      old_in    = old_ff;
      look_slot = slot_ff;
      look_len  = '0;
      look_cpl  = 1'b0;
      go        = 1'b0;
      fresh     = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               priority if (req_operation == OP_CLEAR) begin
                  valid_in  = '0;
                  cpl_in    = '0;
                  len_in    = '0;
                  bitmap_in = '0;
                  strobe_in = 1'b1;
                  status_in = STAT_OK;
               end else if (!req_current_flag) begin
                  strobe_in = 1'b1;
                  status_in = STAT_NEXT;
               end else if (bad_sec) begin
                  strobe_in = 1'b1;
                  status_in = STAT_BAD_SECTION;
               end else begin
                  rver_in  = req_version;
                  rkey_in  = req_table_key;
                  rsec_in  = req_section_index;
                  rlen_in  = {1'b0, req_last_index} + LEN_W'(1);
                  state_in = S_LOOK;
               end
            end
         end
         S_LOOK: begin
            priority if (match.hit && newer_version(rver_ff, ver_ff[hit_slot])) begin
               valid_in  = '0;
               cpl_in    = '0;
               len_in    = '0;
               bitmap_in = '0;
               look_slot = hit_slot;
               go        = 1'b1;
               fresh     = 1'b1;
            end else if (match.hit && (rver_ff != ver_ff[hit_slot])) begin
               strobe_in = 1'b1;
               status_in = STAT_OLD_VERSION;
               state_in  = S_IDLE;
            end else if (match.hit) begin
               look_slot = hit_slot;
               go        = 1'b1;
            end else if (match.free) begin
               look_slot = match.free_idx[TIDX_W-1:0];
               go        = 1'b1;
               fresh     = 1'b1;
            end else begin
               strobe_in = 1'b1;
               status_in = STAT_TABLE_FULL;
               state_in  = S_IDLE;
            end
            if (go) begin
               if (fresh) begin
                  valid_in[look_slot]  = 1'b1;
                  key_in[look_slot]    = rkey_ff;
                  ver_in[look_slot]    = rver_ff;
                  bitmap_in[look_slot] = '0;
               end else begin
                  look_len = len_ff[look_slot];
                  look_cpl = cpl_ff[look_slot];
               end
               cpl_in[look_slot] = look_cpl && !(rlen_ff > look_len);
               len_in[look_slot] = rlen_ff;
               slot_in           = look_slot;
               word_in           = '0;
               all_in            = 1'b1;
               old_in            = 1'b0;
               state_in          = S_SWEEP;
            end
         end
         S_SWEEP: begin
            bitmap_in[slot_ff][word_ff] = word_new;
            all_in = all_ff & wflags.all_set;
            old_in = old_ff | wflags.old_bit;
            if (word_ff == WIDX_W'(WORDS - 1)) begin
               state_in = S_DONE;
            end else begin
               word_in = word_ff + WIDX_W'(1);
            end
         end
         S_DONE: begin
            strobe_in = 1'b1;
            state_in  = S_IDLE;
            priority if (cpl_ff[slot_ff]) begin
               status_in = any_open ? STAT_REPEAT : STAT_REPEAT_COMPLETE;
            end else if (all_ff) begin
               cpl_in[slot_ff] = 1'b1;
               status_in       = STAT_COMPLETE;
            end else begin
               status_in = old_ff ? STAT_REPEAT : STAT_OK;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         strobe_ff <= 1'b0;
         valid_ff  <= '0;
         cpl_ff    <= '0;
         len_ff    <= '0;
         bitmap_ff <= '0;
      end else begin
         state_ff  <= state_in;
         strobe_ff <= strobe_in;
         valid_ff  <= valid_in;
         cpl_ff    <= cpl_in;
         len_ff    <= len_in;
         bitmap_ff <= bitmap_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff <= status_in;
      key_ff    <= key_in;
      ver_ff    <= ver_in;
      rver_ff   <= rver_in;
      rkey_ff   <= rkey_in;
      rsec_ff   <= rsec_in;
      rlen_ff   <= rlen_in;
      slot_ff   <= slot_in;
      word_ff   <= word_in;
      all_ff    <= all_in;
      old_ff    <= old_in;
   end

endmodule
`default_nettype wire

// File: hdl/sct_lookup.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_lookup
// Key match and first free entry search over the entry table.
// ----------------------------------------------------------------------------
module sct_lookup #(
   parameter int MAX_TABLES = 16
) (
   input  wire logic [MAX_TABLES-1:0]       valid,
   input  wire logic [MAX_TABLES-1:0][15:0] keys,
   input  wire logic [15:0]                 key,
   output sct_pkg::sct_match_type           match
);
   import sct_pkg::*;

   always_comb begin
      match = '0;
      for (int i = MAX_TABLES - 1; i >= 0; i--) begin
         if (valid[i] && (keys[i] == key)) begin
            match.hit     = 1'b1;
            match.hit_idx = IDX_MAX_W'(i);
         end
         if (!valid[i]) begin
            match.free     = 1'b1;
            match.free_idx = IDX_MAX_W'(i);
         end
      end
   end

endmodule
`default_nettype wire

// File: hdl/sct_word_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sct_word_unit
// One 64-bit bitmap word step: trim to length, mark section, check fill.
// ----------------------------------------------------------------------------
module sct_word_unit (
   input  wire logic [sct_pkg::WORD_W-1:0]     word_cur,
   input  wire logic [sct_pkg::WIDX_MAX_W-1:0] word_idx,
   input  wire logic [sct_pkg::LEN_W-1:0]      len,
   input  wire logic [7:0]                     sec,
   input  wire logic                           set_en,
   output logic      [sct_pkg::WORD_W-1:0]     word_new,
   output sct_pkg::sct_word_type               flags
);
   import sct_pkg::*;

   logic [LEN_W-1:0]  base;
   logic [LEN_W-1:0]  rel;
   logic [WORD_W-1:0] mask;
   logic              sec_here;
   logic [WORD_W-1:0] sec_bit;

   assign base     = {1'b0, word_idx, 6'b0};
   assign rel      = len - base;
   assign sec_here = (sec[7:6] == word_idx);
   assign sec_bit  = (set_en && sec_here) ? (WORD_W'(1) << sec[5:0]) : '0;

   always_comb begin
      priority if (len <= base) begin
         mask = '0;
      end else if (rel >= LEN_W'(WORD_W)) begin
         mask = '1;
      end else begin
         mask = (WORD_W'(1) << rel[5:0]) - WORD_W'(1);
      end
   end

   assign word_new      = (word_cur & mask) | sec_bit;
   assign flags.all_set = &(word_new | ~mask);
   assign flags.old_bit = sec_here & word_cur[sec[5:0]];

endmodule
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for si_section_completeness_tracker. A directed table
// covers clears, next-table and bad-section headers, single and full-size
// tables, version wraparound, old versions, resizing and repeats. Random
// traffic follows, mostly over a pool of keys with rarely changing versions and lengths. Each
// status is checked against an in-bench tracker model or a directed row's fixed status.
// ----------------------------------------------------------------------------
module testbench;
   import sct_pkg::*;

   localparam int NUM_ENTRIES  = 16;
   localparam int NUM_SECTIONS = 256;
   localparam int POOL_SIZE    = 24;
   localparam int PHASE_ITEMS  = 484;
   localparam int DRAIN_CYCLES = 20;

   typedef struct packed {
      logic       op;
      logic       cur;
      logic [4:0] ver;
      logic [15:0] key;
      logic [7:0] sec;
      logic [7:0] last;
      logic       typed;
      logic [2:0] status;
   } stim_row_type;

   localparam int NUM_ROWS = 26;
   localparam stim_row_type DIRECTED_ROWS [NUM_ROWS] = '{
      '{OP_CLEAR, 1'b0, 5'd0,  16'h0000, 8'd0,   8'd0,   1'b1, STAT_OK},
      '{OP_TRACK, 1'b0, 5'd31, 16'hFFFF, 8'd255, 8'd0,   1'b1, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd0,  16'h1234, 8'd1,   8'd0,   1'b1, STAT_BAD_SECTION},
      '{OP_TRACK, 1'b1, 5'd0,  16'h1234, 8'd255, 8'd254, 1'b1, STAT_BAD_SECTION},
      '{OP_TRACK, 1'b1, 5'd0,  16'h0000, 8'd0,   8'd0,   1'b1, STAT_COMPLETE},
      '{OP_TRACK, 1'b1, 5'd0,  16'h0000, 8'd0,   8'd0,   1'b1, STAT_REPEAT_COMPLETE},
      '{OP_TRACK, 1'b1, 5'd31, 16'hFFFF, 8'd255, 8'd255, 1'b1, STAT_OK},
      '{OP_TRACK, 1'b1, 5'd31, 16'hFFFF, 8'd255, 8'd255, 1'b1, STAT_REPEAT},
      '{OP_TRACK, 1'b1, 5'd0,  16'h0000, 8'd0,   8'd0,   1'b1, STAT_REPEAT},
      '{OP_TRACK, 1'b1, 5'd5,  16'hFFFF, 8'd0,   8'd1,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd0,  16'h0000, 8'd0,   8'd0,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd4,  16'hFFFF, 8'd1,   8'd1,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd5,  16'hFFFF, 8'd1,   8'd1,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd5,  16'hFFFF, 8'd2,   8'd2,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd5,  16'hFFFF, 8'd0,   8'd0,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd1,  16'h0000, 8'd3,   8'd7,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd5,  16'hFFFF, 8'd0,   8'd0,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd1,  16'h0000, 8'd3,   8'd7,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd0,  16'h0000, 8'd3,   8'd7,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b0, 5'd7,  16'h0000, 8'd0,   8'd255, 1'b1, STAT_NEXT},
      '{OP_CLEAR, 1'b1, 5'd31, 16'hFFFF, 8'd255, 8'd255, 1'b1, STAT_OK},
      '{OP_TRACK, 1'b1, 5'd24, 16'hA5A5, 8'd0,   8'd0,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd11, 16'hA5A5, 8'd0,   8'd0,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd12, 16'hA5A5, 8'd0,   8'd0,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd24, 16'h5A5A, 8'd0,   8'd1,   1'b0, STAT_NEXT},
      '{OP_TRACK, 1'b1, 5'd12, 16'h5A5A, 8'd1,   8'd1,   1'b0, STAT_NEXT}
   };

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic        req_current_flag;
   logic [4:0]  req_version;
   logic [15:0] req_table_key;
   logic [7:0]  req_section_index;
   logic [7:0]  req_last_index;
   logic        rsp_strobe;
   logic [2:0]  rsp_status;

   si_section_completeness_tracker #(
      .MAX_TABLES  (NUM_ENTRIES),
      .MAX_SECTIONS(NUM_SECTIONS)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_current_flag (req_current_flag),
      .req_version      (req_version),
      .req_table_key    (req_table_key),
      .req_section_index(req_section_index),
      .req_last_index   (req_last_index),
      .rsp_strobe       (rsp_strobe),
      .rsp_status       (rsp_status)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // tracker model state
   logic                    seen_valid  [NUM_ENTRIES];
   logic [15:0]             seen_key    [NUM_ENTRIES];
   logic [4:0]              seen_version[NUM_ENTRIES];
   logic [8:0]              seen_length [NUM_ENTRIES];
   logic [NUM_SECTIONS-1:0] seen_bits   [NUM_ENTRIES];
   logic                    seen_done   [NUM_ENTRIES];

   logic [2:0] expected_status_q[$];
   int         mismatch_count;
   int         sender_idle_pct;

   logic [15:0] pool_key [POOL_SIZE];
   logic [4:0]  pool_ver [POOL_SIZE];
   logic [7:0]  pool_last[POOL_SIZE];

   function automatic void reset_entries();
      for (int t = 0; t < NUM_ENTRIES; t++) begin
         seen_valid[t]   = 1'b0;
         seen_key[t]     = '0;
         seen_version[t] = '0;
         seen_length[t]  = '0;
         seen_bits[t]    = '0;
         seen_done[t]    = 1'b0;
      end
   endfunction

   function automatic void open_entry(input int t, input logic [15:0] k, input logic [4:0] vn);
      seen_valid[t]   = 1'b1;
      seen_key[t]     = k;
      seen_version[t] = vn;
      seen_length[t]  = '0;
      seen_bits[t]    = '0;
      seen_done[t]    = 1'b0;
   endfunction

   function automatic logic [2:0] track_header(input logic [15:0] k, input logic [4:0] vn,
                                               input logic [7:0] sec, input logic [8:0] len);
      int                      slot;
      logic [4:0]              old;
      logic [NUM_SECTIONS-1:0] mask;
      logic [2:0]              res;
      slot = -1;
      for (int t = 0; t < NUM_ENTRIES; t++)
         if (slot < 0 && seen_valid[t] && seen_key[t] == k) slot = t;
      if (slot < 0) begin
         for (int t = 0; t < NUM_ENTRIES; t++)
            if (slot < 0 && !seen_valid[t]) slot = t;
         if (slot < 0) return STAT_TABLE_FULL;
         open_entry(slot, k, vn);
      end else begin
         old = seen_version[slot];
         if (vn > old || (vn < WRAP_NEW_BELOW && old >= WRAP_OLD_FROM)) begin
            reset_entries();
            open_entry(slot, k, vn);
         end else if (vn != old) begin
            return STAT_OLD_VERSION;
         end
      end
      mask = ~({NUM_SECTIONS{1'b1}} << len);
      if (len > seen_length[slot]) seen_done[slot] = 1'b0;
      if (len != seen_length[slot]) begin
         seen_bits[slot]   = seen_bits[slot] & mask;
         seen_length[slot] = len;
      end
      if (seen_done[slot]) return STAT_REPEAT_COMPLETE;
      res = seen_bits[slot][sec] ? STAT_REPEAT : STAT_OK;
      seen_bits[slot][sec] = 1'b1;
      if (seen_bits[slot] == mask) begin
         seen_done[slot] = 1'b1;
         return STAT_COMPLETE;
      end
      return res;
   endfunction

   function automatic logic [2:0] predict_status(input logic op, input logic cur,
                                                 input logic [4:0] vn, input logic [15:0] k,
                                                 input logic [7:0] sec, input logic [7:0] last);
      logic [2:0] st;
      if (op == OP_CLEAR) begin
         reset_entries();
         return STAT_OK;
      end
      if (!cur) return STAT_NEXT;
      if (sec > last) return STAT_BAD_SECTION;
      st = track_header(k, vn, sec, {1'b0, last} + 9'd1);
      if (st == STAT_REPEAT_COMPLETE)
         for (int t = 0; t < NUM_ENTRIES; t++)
            if (seen_valid[t] && !seen_done[t]) st = STAT_REPEAT;
      return st;
   endfunction

   function automatic logic [7:0] random_last();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 3) return 8'd255;
      if (pick < 13) return 8'($urandom_range(8, 63));
      return 8'($urandom_range(0, 7));
   endfunction

   task automatic send_item(input logic op, input logic cur, input logic [4:0] vn,
                            input logic [15:0] k, input logic [7:0] sec,
                            input logic [7:0] last, input logic typed,
                            input logic [2:0] typed_status);
      logic [2:0] predicted;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_operation     <= op;
      req_current_flag  <= cur;
      req_version       <= vn;
      req_table_key     <= k;
      req_section_index <= sec;
      req_last_index    <= last;
      do @(posedge clock); while (busy);
      predicted = predict_status(op, cur, vn, k, sec, last);
      expected_status_q.push_back(typed ? typed_status : predicted);
   endtask

   task automatic wait_drained();
      start <= 1'b0;
      do @(posedge clock); while (expected_status_q.size() != 0);
   endtask

   task automatic send_random_item();
      int         pick;
      int         k;
      logic       op;
      logic       cur;
      logic [4:0] vn;
      logic [15:0] key;
      logic [7:0] sec;
      logic [7:0] last;
      pick = $urandom_range(0, 99);
      op   = OP_TRACK;
      cur  = 1'b1;
      vn   = 5'($urandom);
      key  = 16'($urandom);
      sec  = 8'($urandom);
      last = 8'($urandom);
      if (pick < 1) begin
         op = OP_CLEAR;
      end else if (pick < 5) begin
         cur = 1'b0;
      end else if (pick >= 9) begin
         k = $urandom_range(0, POOL_SIZE - 1);
         if ($urandom_range(0, 99) < 1) pool_ver[k] = pool_ver[k] + 5'd1;
         if ($urandom_range(0, 99) < 3) pool_last[k] = random_last();
         key  = pool_key[k];
         vn   = pool_ver[k];
         last = pool_last[k];
         sec  = 8'($urandom_range(0, last));
         if ($urandom_range(0, 99) < 4) vn = pool_ver[k] - 5'($urandom_range(1, 11));
         if ($urandom_range(0, 99) < 3 && last != 8'd255)
            sec = last + 8'($urandom_range(1, 255 - last));
      end
      send_item(op, cur, vn, key, sec, last, 1'b0, STAT_NEXT);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) begin
         if (expected_status_q.size() == 0) begin
            $display("%0t: status %0d with no item pending", $time, rsp_status);
            mismatch_count++;
         end else if (rsp_status !== expected_status_q[0]) begin
            $display("%0t: status mismatch, expected %0d actual %0d",
                     $time, expected_status_q[0], rsp_status);
            mismatch_count++;
            void'(expected_status_q.pop_front());
         end else begin
            void'(expected_status_q.pop_front());
         end
      end
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      mismatch_count    = 0;
      sender_idle_pct   = 8;
      reset             <= 1'b1;
      start             <= 1'b0;
      req_operation     <= OP_TRACK;
      req_current_flag  <= 1'b0;
      req_version       <= '0;
      req_table_key     <= '0;
      req_section_index <= '0;
      req_last_index    <= '0;
      reset_entries();
      for (int p = 0; p < POOL_SIZE; p++) begin
         pool_key[p]  = 16'($urandom);
         pool_ver[p]  = 5'($urandom);
         pool_last[p] = random_last();
      end
      pool_key[0] = 16'h0000;
      pool_key[1] = 16'hFFFF;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      for (int r = 0; r < NUM_ROWS; r++)
         send_item(DIRECTED_ROWS[r].op, DIRECTED_ROWS[r].cur, DIRECTED_ROWS[r].ver,
                   DIRECTED_ROWS[r].key, DIRECTED_ROWS[r].sec, DIRECTED_ROWS[r].last,
                   DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].status);

      for (int phase = 0; phase < 3; phase++) begin
         sender_idle_pct = (phase == 0) ? 8 : (phase == 1) ? 55 : 0;
         wait_drained();
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if ($urandom_range(0, 99) < 1) wait_drained();
            send_random_item();
         end
      end

      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && expected_status_q.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
